>>> design/rme_pkg.sv
// Package for the rotation matrix to Euler angles block.
// Holds fixed-point widths, the CORDIC arctangent table and shared constants.
// No dependencies.
package rme_pkg;

    localparam int IN_W   = 18;
    localparam int ANG_W  = 19;
    localparam int THR_W  = 17;
    localparam int SUM_W  = 37;
    localparam int SY_W   = 19;
    localparam int CW     = 40;
    localparam int ZW     = 28;
    localparam int PRESHIFT = 12;

    localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [ANG_W-1:0] PI_Q16   = 19'sd205887;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0: v = 28'sd13176795;
            5'd1: v = 28'sd7778716;
            5'd2: v = 28'sd4110060;
            5'd3: v = 28'sd2086331;
            5'd4: v = 28'sd1047214;
            5'd5: v = 28'sd524117;
            5'd6: v = 28'sd262123;
            5'd7: v = 28'sd131069;
            5'd8: v = 28'sd65536;
            5'd9: v = 28'sd32768;
            5'd10: v = 28'sd16384;
            5'd11: v = 28'sd8192;
            5'd12: v = 28'sd4096;
            5'd13: v = 28'sd2048;
            5'd14: v = 28'sd1024;
            5'd15: v = 28'sd512;
            5'd16: v = 28'sd256;
            5'd17: v = 28'sd128;
            5'd18: v = 28'sd64;
            5'd19: v = 28'sd32;
            5'd20: v = 28'sd16;
            5'd21: v = 28'sd8;
            5'd22: v = 28'sd4;
            5'd23: v = 28'sd2;
            5'd24: v = 28'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 fixed;
        logic signed [ANG_W-1:0] fixed_val;
    } rme_cordic_t;

endpackage

>>> design/rotation_matrix_to_euler.sv
// Top level: rotation matrix to ZYX Euler angles with gimbal lock detection.
// Depends on rme_pkg, rme_sqrt and rme_cordic.
//
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    r00 r10 r20 r21 r22 r11 r12
// m_        out        m_valid/m_ready    roll, pitch, yaw angles, singular
// cfg       in         cfg_we             singular_threshold
//
// One item per cycle while the output is taken or empty; the path runs through the input
// and product registers, the square-root stages, a setup register and the CORDIC stages.
// Reset clears valid bits and sets the threshold to 1. When the output item is
// not taken the whole pipeline holds; s_ready is high whenever m_ready is or the
// output slot is empty.
module rotation_matrix_to_euler
    import rme_pkg::*;
#(
    parameter int CORDIC_STEPS = 18
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [THR_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_r00,
    input  logic signed [IN_W-1:0]  s_r10,
    input  logic signed [IN_W-1:0]  s_r20,
    input  logic signed [IN_W-1:0]  s_r21,
    input  logic signed [IN_W-1:0]  s_r22,
    input  logic signed [IN_W-1:0]  s_r11,
    input  logic signed [IN_W-1:0]  s_r12,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [ANG_W-1:0] m_roll_angle,
    output logic signed [ANG_W-1:0] m_pitch_angle,
    output logic signed [ANG_W-1:0] m_yaw_angle,
    output logic                    m_singular
);

    localparam int TAG_W = 7 * IN_W;
    localparam int CLAT  = CORDIC_STEPS + 2;

    logic               en;
    logic [THR_W-1:0]   thr_reg;
    logic               v0_reg;
    logic signed [IN_W-1:0] a_reg [7];
    logic signed [2*IN_W-1:0] p0_reg, p1_reg;
    logic               v1_reg;
    logic [TAG_W-1:0]   tag1_reg;
    logic [SUM_W-1:0]   sum_c;
    logic               sq_valid;
    logic [SY_W-1:0]    sq_root;
    logic [TAG_W-1:0]   sq_tag;
    logic signed [IN_W-1:0] e00, e10, e20, e21, e22, e11, e12;
    logic               sing_c;
    logic               v2_reg;
    logic               sing2_reg;
    logic signed [SY_W+1:0] py_reg, px_reg, ry_reg, rx_reg, yy_reg, yx_reg;
    logic [CLAT-1:0]    vl_reg;
    logic [CLAT-1:0]    sl_reg;
    logic signed [ANG_W-1:0] roll_c, pitch_c, yaw_c;

    assign en      = m_ready || !m_valid;
    assign s_ready = en;
    assign m_valid = vl_reg[CLAT-1];
    assign m_singular = sl_reg[CLAT-1];
    assign m_roll_angle  = roll_c;
    assign m_pitch_angle = pitch_c;
    assign m_yaw_angle   = m_singular ? '0 : yaw_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_W'(1);
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vl_reg <= '0;
        end else if (en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= sq_valid;
            vl_reg <= {vl_reg[CLAT-2:0], v2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0] <= s_r00;
            a_reg[1] <= s_r10;
            a_reg[2] <= s_r20;
            a_reg[3] <= s_r21;
            a_reg[4] <= s_r22;
            a_reg[5] <= s_r11;
            a_reg[6] <= s_r12;
            p0_reg   <= a_reg[0] * a_reg[0];
            p1_reg   <= a_reg[1] * a_reg[1];
            tag1_reg <= {a_reg[0], a_reg[1], a_reg[2], a_reg[3],
                         a_reg[4], a_reg[5], a_reg[6]};
            sl_reg   <= {sl_reg[CLAT-2:0], sing2_reg};
        end
    end

    assign sum_c = SUM_W'(unsigned'(p0_reg)) + SUM_W'(unsigned'(p1_reg));

    rme_sqrt #(.TAG_W(TAG_W)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v1_reg), .in_sum(sum_c), .in_tag(tag1_reg),
        .out_valid(sq_valid), .out_root(sq_root), .out_tag(sq_tag)
    );

    assign {e00, e10, e20, e21, e22, e11, e12} = sq_tag;
    assign sing_c = {1'b0, sq_root} < {3'b000, thr_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            sing2_reg <= sing_c;
            py_reg <= -(SY_W+2)'(e20);
            px_reg <= (SY_W+2)'({1'b0, sq_root});
            ry_reg <= sing_c ? -(SY_W+2)'(e12) : (SY_W+2)'(e21);
            rx_reg <= sing_c ? (SY_W+2)'(e11) : (SY_W+2)'(e22);
            yy_reg <= (SY_W+2)'(e10);
            yx_reg <= (SY_W+2)'(e00);
        end
    end

    rme_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_y(ry_reg), .in_x(rx_reg), .out_angle(roll_c)
    );

    rme_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_y(py_reg), .in_x(px_reg), .out_angle(pitch_c)
    );

    rme_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_y(yy_reg), .in_x(yx_reg), .out_angle(yaw_c)
    );

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_roll_angle))
        else $error("output item changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    a_yaw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_yaw_angle == 0)
        else $error("yaw nonzero in singular case");

endmodule

>>> design/rme_sqrt.sv
// Pipelined integer square root of the sum r00^2 + r10^2, one result bit per stage.
// Depends on rme_pkg. Carries a tag alongside the data; stalls with a shared enable.
module rme_sqrt
    import rme_pkg::*;
#(
    parameter int TAG_W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [SUM_W-1:0]      in_sum,
    input  logic [TAG_W-1:0]      in_tag,
    output logic                  out_valid,
    output logic [SY_W-1:0]       out_root,
    output logic [TAG_W-1:0]      out_tag
);

    localparam int NS = SY_W;

    logic [NS:0]             vld_reg;
    logic [SUM_W+1:0]        rem_reg  [NS+1];
    logic [SY_W-1:0]         root_reg [NS+1];
    logic [SUM_W-1:0]        val_reg  [NS+1];
    logic [TAG_W-1:0]        tag_reg  [NS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            val_reg[0]  <= in_sum;
            tag_reg[0]  <= in_tag;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [SUM_W+1:0] rem_sh;
        logic [SUM_W+1:0] trial;
        always_comb begin
            rem_sh = {rem_reg[k][SUM_W-1:0],
                      val_reg[k][2*(NS-1-k)+1 - ((2*(NS-1-k)+1 >= SUM_W) ? 1 : 0)],
                      val_reg[k][2*(NS-1-k)]};
            if (2*(NS-1-k)+1 >= SUM_W) begin
                rem_sh = {rem_reg[k][SUM_W-1:0], 1'b0, val_reg[k][2*(NS-1-k)]};
            end
            trial = {{(SUM_W+2-SY_W-2){1'b0}}, root_reg[k], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                val_reg[k+1] <= val_reg[k];
                tag_reg[k+1] <= tag_reg[k];
                if (rem_sh >= trial) begin
                    rem_reg[k+1]  <= rem_sh - trial;
                    root_reg[k+1] <= {root_reg[k][SY_W-2:0], 1'b1};
                end else begin
                    rem_reg[k+1]  <= rem_sh;
                    root_reg[k+1] <= {root_reg[k][SY_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[NS];
    assign out_root  = root_reg[NS];
    assign out_tag   = tag_reg[NS];

endmodule

>>> design/rme_cordic.sv
// Pipelined vectoring CORDIC for atan2 with quadrant fixup and Q3.16 rounding.
// Depends on rme_pkg. One stage per iteration plus an entry and an output stage.
module rme_cordic
    import rme_pkg::*;
#(
    parameter int STEPS = 18
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic signed [SY_W+1:0]   in_y,
    input  logic signed [SY_W+1:0]   in_x,
    output logic signed [ANG_W-1:0]  out_angle
);

    rme_cordic_t st_reg [STEPS+1];
    rme_cordic_t st0_next;
    logic signed [ANG_W-1:0] angle_reg;
    logic signed [ANG_W-1:0] angle_next_c;

    always_comb begin
        logic signed [CW-1:0] xe;
        logic signed [CW-1:0] ye;
        xe = CW'(in_x);
        ye = CW'(in_y);
        st0_next.fixed     = 1'b0;
        st0_next.fixed_val = '0;
        st0_next.z         = '0;
        if (in_y == 0) begin
            st0_next.fixed     = 1'b1;
            st0_next.fixed_val = (in_x < 0) ? PI_Q16 : '0;
        end else if (in_x == 0) begin
            st0_next.fixed     = 1'b1;
            st0_next.fixed_val = (in_y > 0) ? 19'sd102944 : -19'sd102944;
        end else if (in_x < 0) begin
            st0_next.z = (in_y > 0) ? PI_Q24 : -PI_Q24;
            xe = -xe;
            ye = -ye;
        end
        st0_next.x = xe <<< PRESHIFT;
        st0_next.y = ye <<< PRESHIFT;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_it
        localparam logic [4:0] S = 5'(i % 32);
        rme_cordic_t nx;
        always_comb begin
            nx = st_reg[i];
            if (st_reg[i].y >= 0) begin
                nx.x = st_reg[i].x + (st_reg[i].y >>> S);
                nx.y = st_reg[i].y - (st_reg[i].x >>> S);
                nx.z = st_reg[i].z + atan_entry(S);
            end else begin
                nx.x = st_reg[i].x - (st_reg[i].y >>> S);
                nx.y = st_reg[i].y + (st_reg[i].x >>> S);
                nx.z = st_reg[i].z - atan_entry(S);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i+1] <= nx;
            end
        end
    end

    always_comb begin
        logic signed [ZW-1:0] r;
        r = (st_reg[STEPS].z + ZW'(128)) >>> 8;
        out_angle = angle_reg;
        if (r > ZW'(PI_Q16)) begin
            r = ZW'(PI_Q16);
        end
        if (r < -ZW'(PI_Q16)) begin
            r = -ZW'(PI_Q16);
        end
        if (st_reg[STEPS].fixed) begin
            r = ZW'(st_reg[STEPS].fixed_val);
        end
        angle_next_c = r[ANG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
        end else if (en) begin
            angle_reg <= angle_next_c;
        end
    end

endmodule

>>> test/tb_rotation_matrix_to_euler.sv
// Testbench for rotation_matrix_to_euler: drives rotation matrices, predicts the Euler
// angles and singular flag with its own fixed-point CORDIC model and compares every item.
// Depends on rme_pkg and the rotation_matrix_to_euler RTL.
module tb_rotation_matrix_to_euler;
    import rme_pkg::*;

    localparam int STEPS = 18;
    localparam int LATENCY = 2 + 20 + 1 + STEPS + 2;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        logic                    sing;
    } angles_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [THR_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [IN_W-1:0] s_r00 = '0, s_r10 = '0, s_r20 = '0, s_r21 = '0;
    logic signed [IN_W-1:0] s_r22 = '0, s_r11 = '0, s_r12 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [ANG_W-1:0] m_roll_angle, m_pitch_angle, m_yaw_angle;
    logic m_singular;

    angles_t expected_angles[$];
    logic [THR_W-1:0] threshold = 17'd1;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int idle_cycles = 0;
    bit failed = 0;

    rotation_matrix_to_euler #(.CORDIC_STEPS(STEPS)) dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_r00(s_r00), .s_r10(s_r10), .s_r20(s_r20), .s_r21(s_r21),
        .s_r22(s_r22), .s_r11(s_r11), .s_r12(s_r12),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_roll_angle(m_roll_angle), .m_pitch_angle(m_pitch_angle),
        .m_yaw_angle(m_yaw_angle), .m_singular(m_singular)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint quantize_angle(longint z);
        longint a;
        a = floor_shift(z + 128, 8);
        if (a > 205887) a = 205887;
        if (a < -205887) a = -205887;
        return a;
    endfunction

    function automatic longint arctan_q16(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        int s;
        z = 0;
        if (y == 0) return (x < 0) ? 205887 : 0;
        if (x == 0) return quantize_angle(y > 0 ? 26353589 : -26353589);
        if (x < 0) begin
            z = (y > 0) ? 52707179 : -52707179;
            x = -x;
            y = -y;
        end
        x = x * 4096;
        y = y * 4096;
        for (int i = 0; i < STEPS; i++) begin
            s = i % 32;
            xs = floor_shift(x, s);
            ys = floor_shift(y, s);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_entry(s[4:0]));
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_entry(s[4:0]));
            end
        end
        return quantize_angle(z);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic angles_t predict_angles(logic signed [IN_W-1:0] r00, r10, r20, r21,
                                               logic signed [IN_W-1:0] r22, r11, r12);
        angles_t a;
        longint sy;
        longint c00, c10;
        c00 = r00;
        c10 = r10;
        sy = int_sqrt(c00 * c00 + c10 * c10);
        a.sing = sy < longint'(threshold);
        a.pitch = ANG_W'(arctan_q16(-longint'(r20), sy));
        if (!a.sing) begin
            a.roll = ANG_W'(arctan_q16(r21, r22));
            a.yaw = ANG_W'(arctan_q16(r10, r00));
        end else begin
            a.roll = ANG_W'(arctan_q16(-longint'(r12), r11));
            a.yaw = '0;
        end
        return a;
    endfunction

    task automatic send_matrix(logic signed [IN_W-1:0] r00, r10, r20, r21,
                               logic signed [IN_W-1:0] r22, r11, r12);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_r00 <= r00; s_r10 <= r10; s_r20 <= r20; s_r21 <= r21;
        s_r22 <= r22; s_r11 <= r11; s_r12 <= r12;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_angles.push_back(predict_angles(r00, r10, r20, r21, r22, r11, r12));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_angles.size() == 0) begin
                $display("%0t: unexpected item roll=%0d pitch=%0d yaw=%0d singular=%0d",
                         $time, m_roll_angle, m_pitch_angle, m_yaw_angle, m_singular);
                failed = 1;
            end else begin
                angles_t e;
                e = expected_angles.pop_front();
                if (m_roll_angle !== e.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time, e.roll, m_roll_angle);
                    failed = 1;
                end
                if (m_pitch_angle !== e.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                             m_pitch_angle);
                    failed = 1;
                end
                if (m_yaw_angle !== e.yaw) begin
                    $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, m_yaw_angle);
                    failed = 1;
                end
                if (m_singular !== e.sing) begin
                    $display("%0t: singular expected %0d actual %0d", $time, e.sing,
                             m_singular);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [IN_W-1:0] pick_element();
        case ($urandom_range(9))
            0: return 18'sh1FFFF;
            1: return -18'sh20000;
            2: return 18'sd65536;
            3: return -18'sd65536;
            4: return '0;
            5: return IN_W'($urandom_range(40) - 20);
            6: return IN_W'($urandom);
            default: return IN_W'($urandom_range(131072) - 65536);
        endcase
    endfunction

    task automatic send_unit_matrix(int shape);
        longint c;
        longint s;
        real a;
        a = ($urandom_range(62831) / 10000.0) - 3.14159;
        c = longint'($cos(a) * 65536.0);
        s = longint'($sin(a) * 65536.0);
        case (shape)
            0: send_matrix(IN_W'(c), IN_W'(s), pick_element(), pick_element(),
                           pick_element(), pick_element(), pick_element());
            1: send_matrix(IN_W'($urandom_range(6) - 3), IN_W'($urandom_range(6) - 3),
                           ($urandom_range(1) ? 18'sd65536 : -18'sd65536), pick_element(),
                           pick_element(), IN_W'(c), IN_W'(s));
            default: send_matrix(pick_element(), pick_element(), pick_element(),
                                 pick_element(), pick_element(), pick_element(),
                                 pick_element());
        endcase
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        threshold = v;
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_matrix(65536, 0, 0, 0, 65536, 65536, 0);
        send_matrix(-65536, 0, 0, 0, -65536, -65536, 0);
        send_matrix(0, 0, 0, 0, 0, 0, 0);
        send_matrix(0, 65536, 65536, 65536, 0, 0, -65536);
        send_matrix(0, -65536, -65536, -65536, 0, 0, 65536);
        send_matrix(0, 0, 65536, 5, -7, -65536, 3);
        send_matrix(0, 0, -65536, -5, 7, 0, 65536);
        send_matrix(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF,
                    18'sh1FFFF, 18'sh1FFFF);
        send_matrix(-18'sh20000, -18'sh20000, -18'sh20000, -18'sh20000, -18'sh20000,
                    -18'sh20000, -18'sh20000);
        send_matrix(-46341, 46341, 1, -46341, -46341, 1, -1);
        send_matrix(46341, -46341, -1, 46341, -46341, -1, 1);
        send_matrix(-1, 1, 0, 1, -1, 1, 1);
        send_matrix(0, 0, 0, 0, 1, 1, 0);
        send_matrix(1, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_thresholds();
        write_threshold(17'd65536);
        send_matrix(46340, 46340, 1, 1, 1, 1, 1);
        send_matrix(65535, 0, 2, 3, 4, 5, 6);
        send_matrix(65536, 0, 2, 3, 4, 5, 6);
        write_threshold(17'd0);
        send_matrix(0, 0, 65536, 1, 1, 1, 1);
        write_threshold(17'h1FFFF);
        send_matrix(65536, 65536, 0, 1, 1, 1, 1);
        send_matrix(-18'sh20000, 0, 0, 1, 1, 1, 1);
        write_threshold(17'd1);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 59) write_threshold(THR_W'($urandom_range(65536)));
            send_unit_matrix($urandom_range(2));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 300;
        for (int i = 0; i < 100; i++) send_unit_matrix($urandom_range(2));
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_thresholds();
        test_random_phase(0, 0, 400);
        test_random_phase(87, 0, 300);
        test_random_phase(0, 87, 300);
        test_random_phase(33, 33, 330);
        test_backpressure();
        write_threshold(17'd1);
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
